[rtl/core/iale_pkg.sv]
// shared types and constants for the indexed array list engine
// used by iale_ctrl, iale_dpath and indexed_array_list_engine; no dependencies
package iale_pkg;

    localparam int unsigned DEPTH_DEF = 64;
    localparam int unsigned CNT_W     = 7;
    localparam int unsigned POS_W     = 6;
    localparam int unsigned WORD_W    = 32;
    localparam int unsigned KIND_W    = 3;
    localparam int unsigned ST_W      = 2;

    typedef enum logic [KIND_W-1:0] {
        REQ_APPEND = 3'd0,
        REQ_INSERT = 3'd1,
        REQ_EDIT   = 3'd2,
        REQ_DELETE = 3'd3,
        REQ_READ   = 3'd4
    } t_kind;

    typedef enum logic [ST_W-1:0] {
        ST_DONE   = 2'd0,
        ST_FULL   = 2'd1,
        ST_BADPOS = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        WR_AT_COUNT = 2'd0,
        WR_AT_POS   = 2'd1,
        WR_AT_IDX   = 2'd2
    } t_wr_sel;

    typedef enum logic {
        RD_AT_POS = 1'b0,
        RD_AT_NBR = 1'b1
    } t_rd_sel;

    typedef struct packed {
        logic    capture;
        logic    wr_en;
        t_wr_sel wr_sel;
        logic    rd_en;
        t_rd_sel rd_sel;
        logic    idx_load;
        logic    idx_step;
        logic    count_inc;
        logic    count_dec;
        logic    finish;
        t_status status;
        logic    out_rdata;
    } t_cmd;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic              full;
        logic              pos_ok;
        logic              shift_done;
    } t_stat;

endpackage

[rtl/core/indexed_array_list_engine.sv]
// A transaction is taken at a clock edge with start high and busy low, and
// gives exactly one result, shown for one cycle with o_valid; the receiver
// cannot stall it. Entries sit in a single-port-write, registered-read memory
// of DEPTH words, so insert and delete move each entry with a read state and
// a write state. Append, edit, refusals and unknown kinds finish in the decode
// state, read passes through a read-out state, and insert and delete step one
// entry at a time between the position and the fill count held before the
// transaction. busy drops as o_valid rises.
// The entries have no reset; the fill count and capacity (64) do.
// depends on iale_pkg, iale_ctrl and iale_dpath
module indexed_array_list_engine
    import iale_pkg::*;
#(
    parameter int unsigned DEPTH = DEPTH_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cap_we,
    input  logic [CNT_W-1:0]         i_cap_wdata,
    input  logic                     start,
    output logic                     busy,
    input  logic [KIND_W-1:0]        i_req_type,
    input  logic [POS_W-1:0]         i_position,
    input  logic signed [WORD_W-1:0] i_word_in,
    output logic                     o_valid,
    output logic [ST_W-1:0]          o_status,
    output logic signed [WORD_W-1:0] o_word_out,
    output logic [CNT_W-1:0]         o_fill_count,
    output logic                     o_is_empty,
    output logic                     o_is_full
);

    t_cmd  cmd;
    t_stat stat;

    iale_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    iale_dpath #(
        .DEPTH (DEPTH)
    ) u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cap_we     (i_cap_we),
        .i_cap_wdata  (i_cap_wdata),
        .i_req_type   (i_req_type),
        .i_position   (i_position),
        .i_word_in    (i_word_in),
        .i_cmd        (cmd),
        .o_stat       (stat),
        .o_valid      (o_valid),
        .o_status     (o_status),
        .o_word_out   (o_word_out),
        .o_fill_count (o_fill_count),
        .o_is_empty   (o_is_empty),
        .o_is_full    (o_is_full)
    );

endmodule

[rtl/core/iale_ctrl.sv]
// request sequencer: decodes each transaction and steps the entry shifts
// depends on iale_pkg; drives iale_dpath through t_cmd
module iale_ctrl
    import iale_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  start,
    output logic  busy,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    typedef enum logic [4:0] {
        S_IDLE     = 5'b00001,
        S_DECIDE   = 5'b00010,
        S_RD       = 5'b00100,
        S_WR       = 5'b01000,
        S_READ_OUT = 5'b10000
    } t_state;

    t_state r_state;
    t_state n_state;

    assign busy = (r_state != S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_DECIDE;
                end
            end
            S_DECIDE: begin
                n_state = S_IDLE;
                priority if (i_stat.kind == REQ_APPEND) begin
                    o_cmd.finish = 1'b1;
                    if (i_stat.full) begin
                        o_cmd.status = ST_FULL;
                    end else begin
                        o_cmd.wr_en     = 1'b1;
                        o_cmd.wr_sel    = WR_AT_COUNT;
                        o_cmd.count_inc = 1'b1;
                    end
                end else if (i_stat.kind == REQ_INSERT) begin
                    if (i_stat.full) begin
                        o_cmd.finish = 1'b1;
                        o_cmd.status = ST_FULL;
                    end else if (!i_stat.pos_ok) begin
                        o_cmd.finish = 1'b1;
                        o_cmd.status = ST_BADPOS;
                    end else begin
                        o_cmd.idx_load = 1'b1;
                        n_state        = S_RD;
                    end
                end else if (i_stat.kind == REQ_EDIT) begin
                    o_cmd.finish = 1'b1;
                    if (!i_stat.pos_ok) begin
                        o_cmd.status = ST_BADPOS;
                    end else begin
                        o_cmd.wr_en  = 1'b1;
                        o_cmd.wr_sel = WR_AT_POS;
                    end
                end else if (i_stat.kind == REQ_DELETE) begin
                    if (!i_stat.pos_ok) begin
                        o_cmd.finish = 1'b1;
                        o_cmd.status = ST_BADPOS;
                    end else begin
                        o_cmd.idx_load = 1'b1;
                        n_state        = S_RD;
                    end
                end else if (i_stat.kind == REQ_READ) begin
                    if (!i_stat.pos_ok) begin
                        o_cmd.finish = 1'b1;
                        o_cmd.status = ST_BADPOS;
                    end else begin
                        o_cmd.rd_en  = 1'b1;
                        o_cmd.rd_sel = RD_AT_POS;
                        n_state      = S_READ_OUT;
                    end
                end else begin
                    o_cmd.finish = 1'b1;
                end
            end
            S_RD: begin
                if (i_stat.shift_done) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                    if (i_stat.kind == REQ_INSERT) begin
                        o_cmd.wr_en     = 1'b1;
                        o_cmd.wr_sel    = WR_AT_POS;
                        o_cmd.count_inc = 1'b1;
                    end else begin
                        o_cmd.count_dec = 1'b1;
                    end
                end else begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_sel = RD_AT_NBR;
                    n_state      = S_WR;
                end
            end
            S_WR: begin
                o_cmd.wr_en    = 1'b1;
                o_cmd.wr_sel   = WR_AT_IDX;
                o_cmd.idx_step = 1'b1;
                n_state        = S_RD;
            end
            S_READ_OUT: begin
                o_cmd.finish    = 1'b1;
                o_cmd.out_rdata = 1'b1;
                n_state         = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    a_accept_decides: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (r_state == S_DECIDE))
        else $error("accepted transaction not decoded");

endmodule

[rtl/core/iale_dpath.sv]
// entry memory, fill count, capacity register, shift index and result registers
// depends on iale_pkg; controlled by iale_ctrl through t_cmd
module iale_dpath
    import iale_pkg::*;
#(
    parameter int unsigned DEPTH = DEPTH_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cap_we,
    input  logic [CNT_W-1:0]         i_cap_wdata,
    input  logic [KIND_W-1:0]        i_req_type,
    input  logic [POS_W-1:0]         i_position,
    input  logic signed [WORD_W-1:0] i_word_in,
    input  t_cmd                     i_cmd,
    output t_stat                    o_stat,
    output logic                     o_valid,
    output logic [ST_W-1:0]          o_status,
    output logic signed [WORD_W-1:0] o_word_out,
    output logic [CNT_W-1:0]         o_fill_count,
    output logic                     o_is_empty,
    output logic                     o_is_full
);

    localparam int unsigned AW        = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_MAX   = (1 << CNT_W) - 1;
    localparam int unsigned DEPTH_LIM = (DEPTH > CNT_MAX) ? CNT_MAX : DEPTH;
    localparam logic [CNT_W-1:0] LIM  = CNT_W'(DEPTH_LIM);

    function automatic logic [AW-1:0] to_addr(input logic [CNT_W-1:0] v);
        logic [AW+CNT_W-1:0] ext;
        ext = {{AW{1'b0}}, v};
        return ext[AW-1:0];
    endfunction

    logic [WORD_W-1:0] mem [DEPTH];

    logic [KIND_W-1:0]        r_kind;
    logic [POS_W-1:0]         r_pos;
    logic [WORD_W-1:0]        r_word;
    logic [CNT_W-1:0]         r_count;
    logic [CNT_W-1:0]         n_count;
    logic [CNT_W-1:0]         r_cap;
    logic [CNT_W-1:0]         r_idx;
    logic [WORD_W-1:0]        r_rdata;
    logic                     r_valid;
    logic [ST_W-1:0]          r_status;
    logic [WORD_W-1:0]        r_word_out;
    logic [CNT_W-1:0]         r_fill;
    logic                     r_empty;
    logic                     r_full;

    logic [CNT_W-1:0] eff_cap;
    logic [CNT_W-1:0] pos_ext;
    logic [CNT_W-1:0] nbr;
    logic             is_ins;
    logic [AW-1:0]    wr_addr;
    logic [AW-1:0]    rd_addr;
    logic [WORD_W-1:0] wr_data;

    assign eff_cap = (r_cap > LIM) ? LIM : r_cap;
    assign pos_ext = {1'b0, r_pos};
    assign is_ins  = (r_kind == REQ_INSERT);
    assign nbr     = is_ins ? (r_idx - 1'b1) : (r_idx + 1'b1);

    assign o_stat.kind       = r_kind;
    assign o_stat.full       = (r_count >= eff_cap) || (r_count >= LIM);
    assign o_stat.pos_ok     = (pos_ext < r_count);
    assign o_stat.shift_done = is_ins ? (r_idx == pos_ext)
                                      : (({1'b0, r_idx} + 1'b1) >= {1'b0, r_count});

    always_comb begin
        unique case (i_cmd.wr_sel)
            WR_AT_COUNT: wr_addr = to_addr(r_count);
            WR_AT_POS:   wr_addr = to_addr(pos_ext);
            WR_AT_IDX:   wr_addr = to_addr(r_idx);
            default:     wr_addr = to_addr(r_idx);
        endcase
    end

    assign wr_data = (i_cmd.wr_sel == WR_AT_IDX) ? r_rdata : r_word;
    assign rd_addr = (i_cmd.rd_sel == RD_AT_NBR) ? to_addr(nbr) : to_addr(pos_ext);

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (i_cmd.rd_en) begin
            r_rdata <= mem[rd_addr];
        end
    end

    always_comb begin
        n_count = r_count;
        if (i_cmd.count_inc) begin
            n_count = r_count + 1'b1;
        end else if (i_cmd.count_dec) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_kind <= i_req_type;
            r_pos  <= i_position;
            r_word <= i_word_in;
        end
        if (i_cmd.idx_load) begin
            r_idx <= is_ins ? r_count : pos_ext;
        end else if (i_cmd.idx_step) begin
            r_idx <= nbr;
        end
        if (i_cmd.finish) begin
            r_status   <= i_cmd.status;
            r_word_out <= i_cmd.out_rdata ? r_rdata : '0;
            r_fill     <= n_count;
            r_empty    <= (n_count == '0);
            r_full     <= (n_count >= eff_cap);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_cap   <= CNT_W'(DEPTH_DEF);
            r_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            r_valid <= i_cmd.finish;
            if (i_cap_we) begin
                r_cap <= i_cap_wdata;
            end
        end
    end

    assign o_valid      = r_valid;
    assign o_status     = r_status;
    assign o_word_out   = r_word_out;
    assign o_fill_count = r_fill;
    assign o_is_empty   = r_empty;
    assign o_is_full    = r_full;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= LIM)
        else $error("fill count beyond built depth");

    a_grow_not_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.count_inc |-> !o_stat.full)
        else $error("list grew while full");

    a_shrink_not_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.count_dec |-> (r_count != '0))
        else $error("list shrank while empty");

    a_badpos_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && (r_status != ST_DONE)) |-> (r_word_out == '0))
        else $error("refused transaction returned data");

endmodule
